/* hw/rtl/ppnc_pkg.sv */
// ----------------------------------------------------------------------------
// ppnc_pkg
// Types, constants and per-byte helper functions shared by the portable
// path name checker and its step logic.
// ----------------------------------------------------------------------------
package ppnc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_NAME_BYTES = 2'd0;
    localparam logic [1:0] REG_MAX_SEGMENTS   = 2'd1;
    localparam logic [1:0] REG_MAX_ROOT_BYTES = 2'd2;

    localparam logic [15:0] MAX_NAME_BYTES_RST = 16'd4096;
    localparam logic [7:0]  MAX_SEGMENTS_RST   = 8'd64;
    localparam logic [7:0]  MAX_ROOT_BYTES_RST = 8'd64;

    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_MIN    = 8'h20;
    localparam logic [7:0] CHAR_MAX    = 8'h7E;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // lower-case stems, first byte in the low bits
    localparam logic [23:0] STEM_CON = 24'h6E6F63;
    localparam logic [23:0] STEM_PRN = 24'h6E7270;
    localparam logic [23:0] STEM_AUX = 24'h787561;
    localparam logic [23:0] STEM_NUL = 24'h6C756E;
    localparam logic [23:0] STEM_COM = 24'h6D6F63;
    localparam logic [23:0] STEM_LPT = 24'h74706C;

    localparam logic [2:0] SEG_LEN_SAT  = 3'd7;
    localparam logic [2:0] STEM_LEN_SAT = 3'd5;
    localparam logic [2:0] STEM_BYTES   = 3'd4;

    typedef struct packed {
        logic        root_mode;
        logic        has_char;
        logic [7:0]  char_code;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [15:0] max_name_bytes;
        logic [7:0]  max_segments;
        logic [7:0]  max_root_bytes;
    } cfg_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  seg_count;
        logic [2:0]  seg_len;
        logic        seg_all_dots;
        logic [7:0]  prev_char;
        logic [31:0] stem_chars;
        logic [2:0]  stem_len;
        logic        stem_closed;
        logic        failed;
        logic        mode_root;
    } name_state_t;

    function automatic name_state_t clear_segment(name_state_t s);
        name_state_t r;
        r              = s;
        r.seg_len      = '0;
        r.seg_all_dots = 1'b1;
        r.stem_chars   = '0;
        r.stem_len     = '0;
        r.stem_closed  = 1'b0;
        return r;
    endfunction

    function automatic name_state_t clear_name();
        name_state_t r;
        r            = '0;
        r.byte_count = '0;
        r            = clear_segment(r);
        return r;
    endfunction

    function automatic logic token_char(logic [7:0] c);
        logic ok;
        ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2D ||
             c == CHAR_DOT || c == CHAR_SPACE || c == 8'h28 || c == 8'h29;
        return ok;
    endfunction

    function automatic logic device_stem(name_state_t s);
        logic [23:0] w;
        logic [7:0]  d;
        logic        hit;
        w   = s.stem_chars[23:0];
        d   = s.stem_chars[31:24];
        hit = 1'b0;
        if (s.stem_len == 3'd3)
            hit = w == STEM_CON || w == STEM_PRN || w == STEM_AUX || w == STEM_NUL;
        else if (s.stem_len == 3'd4)
            hit = (w == STEM_COM || w == STEM_LPT) && d >= CHAR_ONE && d <= CHAR_NINE;
        return hit;
    endfunction

    function automatic name_state_t take_char(name_state_t s, logic [7:0] c);
        name_state_t r;
        r = s;
        if (!token_char(c))
            r.failed = 1'b1;
        if (c != CHAR_DOT)
            r.seg_all_dots = 1'b0;
        if (s.seg_len != SEG_LEN_SAT)
            r.seg_len = s.seg_len + 3'd1;
        if (c == CHAR_DOT)
        begin
            r.stem_closed = 1'b1;
        end
        else if (!s.stem_closed)
        begin
            if (s.stem_len < STEM_BYTES)
                r.stem_chars[{s.stem_len[1:0], 3'b000} +: 8] = c | CASE_BIT;
            if (s.stem_len != STEM_LEN_SAT)
                r.stem_len = s.stem_len + 3'd1;
        end
        r.prev_char = c;
        return r;
    endfunction

    function automatic name_state_t close_segment(name_state_t s, logic [7:0] max_seg);
        name_state_t r;
        r = s;
        if (s.seg_len == 3'd0)
            r.failed = 1'b1;
        if (s.seg_all_dots && s.seg_len <= 3'd2)
            r.failed = 1'b1;
        if (s.prev_char == CHAR_DOT || s.prev_char == CHAR_SPACE)
            r.failed = 1'b1;
        if (device_stem(s))
            r.failed = 1'b1;
        if (s.seg_count >= max_seg)
            r.failed = 1'b1;
        else
            r.seg_count = s.seg_count + 8'd1;
        return clear_segment(r);
    endfunction

endpackage

/* hw/rtl/portable_path_name_checker_unit.sv */
// ----------------------------------------------------------------------------
// portable_path_name_checker_unit
// Streams a name one byte per item and returns a safe/unsafe verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries root_mode, has_char, char_code
//   and last. Every item is one byte of the name, or a bare end marker when
//   has_char is low. Only an item with last high produces a result.
//   Output channel (out_valid/out_ready) carries name_safe, one per name.
//   Accepted items land in an input register; the step logic then updates the
//   per-name state and, for a last item, loads the result register.
//   Throughput: one item per cycle while no last item waits behind a held verdict.
//   When the receiver stalls, the verdict holds in the result register and
//   byte items keep flowing; a second last item waits in the input register
//   and in_ready drops until the result is taken.
//   Reset clears all per-name state and loads the limit registers with
//   4096, 64 and 64. cfg_we writes the register selected by cfg_index at the
//   clock edge; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module portable_path_name_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        root_mode,
    input  logic        has_char,
    input  logic [7:0]  char_code,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        name_safe
);
    import ppnc_pkg::*;

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        in_valid_reg;
    name_state_t state_reg;
    name_state_t state_next;
    logic        out_valid_reg;
    logic        name_safe_reg;
    logic        safe_next;
    logic        out_free;
    logic        step_fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign step_fire = in_valid_reg && (!item_reg.last || out_free);
    assign in_ready  = !in_valid_reg || step_fire;

    assign out_valid = out_valid_reg;
    assign name_safe = name_safe_reg;

    ppnc_step u_step (
        .state_cur (state_reg),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .state_nxt (state_next),
        .safe      (safe_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_name_bytes <= MAX_NAME_BYTES_RST;
            cfg_reg.max_segments   <= MAX_SEGMENTS_RST;
            cfg_reg.max_root_bytes <= MAX_ROOT_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_NAME_BYTES: cfg_reg.max_name_bytes <= cfg_data;
                REG_MAX_SEGMENTS:   cfg_reg.max_segments   <= cfg_data[7:0];
                REG_MAX_ROOT_BYTES: cfg_reg.max_root_bytes <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= clear_name();
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step_fire)
                state_reg <= state_next;
            if (step_fire && item_reg.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.root_mode <= root_mode;
            item_reg.has_char  <= has_char;
            item_reg.char_code <= char_code;
            item_reg.last      <= last;
        end
        if (step_fire && item_reg.last)
            name_safe_reg <= safe_next;
    end

    // a verdict only comes from a processed end-of-name item
    a_rose_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_fire && item_reg.last))
        else $error("verdict without end-of-name item");

    // per-name state is cleared after every verdict
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && item_reg.last) |=>
            (state_reg.byte_count == 16'd0 && state_reg.seg_count == 8'd0 &&
             !state_reg.failed && state_reg.stem_len == 3'd0))
        else $error("name state not cleared after verdict");

    // input side only stalls behind a held verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && item_reg.last && out_valid_reg && !out_ready))
        else $error("input stalled without pending verdict");

    a_stem_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stem_len <= STEM_LEN_SAT)
        else $error("stem length beyond saturation");

endmodule

/* hw/rtl/ppnc_step.sv */
// ----------------------------------------------------------------------------
// ppnc_step
// Next-state and verdict logic for one byte item of a name.
// ----------------------------------------------------------------------------
module ppnc_step (
    input  ppnc_pkg::name_state_t state_cur,
    input  ppnc_pkg::item_t       item,
    input  ppnc_pkg::cfg_t        cfg,
    output ppnc_pkg::name_state_t state_nxt,
    output logic                  safe
);
    import ppnc_pkg::*;

    name_state_t t;
    name_state_t t_closed;
    logic        mode;
    logic [7:0]  c;

    assign c = item.char_code;

    always_comb
    begin
        // mode follows the input until the first byte of a name is taken
        mode        = (state_cur.byte_count == 16'd0) ? item.root_mode : state_cur.mode_root;
        t           = state_cur;
        t.mode_root = mode;
        if (item.has_char)
        begin
            if (!mode)
            begin
                if (state_cur.byte_count == 16'd0 && (c == CHAR_SLASH || c == CHAR_BSLASH))
                    t.failed = 1'b1;
                if (c < CHAR_MIN || c > CHAR_MAX || c == CHAR_BSLASH)
                    t.failed = 1'b1;
            end
            if (!mode && c == CHAR_SLASH)
            begin
                t           = close_segment(t, cfg.max_segments);
                t.prev_char = c;
            end
            else
            begin
                t = take_char(t, c);
            end
            if (state_cur.byte_count != 16'hFFFF)
                t.byte_count = state_cur.byte_count + 16'd1;
        end

        t_closed = close_segment(t, cfg.max_segments);
        if (mode)
            safe = !t.failed && t.byte_count != 16'd0 &&
                   t.byte_count <= {8'd0, cfg.max_root_bytes} && !device_stem(t);
        else
            safe = !t_closed.failed && t.byte_count != 16'd0 &&
                   t.byte_count <= cfg.max_name_bytes;

        state_nxt = item.last ? clear_name() : t;
    end

endmodule
